### rtl/swma_pkg.sv
// Shared constants and types for the stack with middle access.
`default_nettype none

package swma_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    // Port field widths.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Request codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    // Status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage : swma_pkg

`default_nettype wire

### rtl/stack_with_middle_access.sv
// Bounded stack with pop, push, peek-middle and delete-middle over one memory port.
//
//  channel | signals                                  | accepted when
//  --------+------------------------------------------+----------------------
//  request | i_valid, i_op, i_value_in, o_stall       | i_valid && !o_stall
//  result  | o_valid, o_value_out, o_status,          | o_valid && !i_stall
//          | o_fill_count, i_stall                    |
//
// A push or any error goes through EXEC and FIN to the result register; a pop or
// a peek also goes through RDW. A delete runs SH_RD and SH_WR for each of the
// count - 1 - count/2 entries moved: one read, one write of the single-port memory.
// Reset clears the fill count and control state; the memory is not cleared.
// The request side stalls while an item is in work; a stalled result holds
// the block in its final state until the result register is free.
`default_nettype none

module stack_with_middle_access
    import swma_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic        [OP_W-1:0]     i_op,
    input  wire logic signed [VALUE_W-1:0]  i_value_in,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [VALUE_W-1:0]       o_value_out,
    output logic        [STATUS_W-1:0]      o_status,
    output logic        [FILL_W-1:0]        o_fill_count
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RDW   = 6'b000100,
        S_SH_RD = 6'b001000,
        S_SH_WR = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [DATA_WIDTH-1:0]   r_value, n_value;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [DATA_WIDTH-1:0]   r_res_value, n_res_value;
    t_status                 r_res_status, n_res_status;

    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value;
    logic [STATUS_W-1:0]     r_out_status;
    logic [FILL_W-1:0]       r_out_fill;

    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   r_rdata;
    logic                    mem_we;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_addr;
    logic [DATA_WIDTH-1:0]   mem_wdata;

    logic                    in_xfer;
    logic                    out_free;
    logic                    more_shift;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Another entry sits above the current hole when idx + 1 is below the count.
    assign more_shift = (CNT_W'(r_idx) + CNT_W'(1)) < r_count;

    // Sequencer: issues at most one memory access per cycle.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_value      = r_value;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_idx;
        mem_wdata    = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op    = t_op'(i_op);
                    n_value = DATA_WIDTH'(i_value_in);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_state      = S_FIN;
                if (r_op == OP_PUSH) begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_addr  = IDX_W'(r_count);
                        mem_wdata = r_value;
                        n_count   = r_count + CNT_W'(1);
                    end
                end else if (r_count == '0) begin
                    n_res_status = ST_EMPTY;
                end else if (r_op == OP_POP) begin
                    mem_re   = 1'b1;
                    mem_addr = IDX_W'(r_count - CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                    n_state  = S_RDW;
                end else begin
                    mem_re   = 1'b1;
                    mem_addr = IDX_W'(r_count >> 1);
                    n_idx    = IDX_W'(r_count >> 1);
                    n_state  = S_RDW;
                end
            end
            S_RDW: begin
                // Read data of the popped or middle entry is now registered.
                n_res_value = r_rdata;
                n_state     = (r_op == OP_DELETE) ? S_SH_RD : S_FIN;
            end
            S_SH_RD: begin
                if (more_shift) begin
                    mem_re   = 1'b1;
                    mem_addr = r_idx + IDX_W'(1);
                    n_state  = S_SH_WR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end
            end
            S_SH_WR: begin
                // Move the entry above down into the hole.
                mem_we    = 1'b1;
                mem_addr  = r_idx;
                mem_wdata = r_rdata;
                n_idx     = r_idx + IDX_W'(1);
                n_state   = S_SH_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op         <= n_op;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    // Single-port entry memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // Result register; it frees as soon as the downstream transfer happens.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_value  <= VALUE_W'(r_res_value);
            r_out_status <= r_res_status;
            r_out_fill   <= FILL_W'(r_count);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value_out  = r_out_value;
    assign o_status     = r_out_status;
    assign o_fill_count = r_out_fill;

endmodule : stack_with_middle_access

`default_nettype wire
